// ===== design/bbcq_pkg.sv =====
// ----------------------------------------------------------------------------
// bbcq_pkg - shared types and constants of the coordinate quantizer
// Sequencer states, frame phases, record and error codes, fixed widths.
// ----------------------------------------------------------------------------
package bbcq_pkg;

   // fixed field widths
   localparam int COORD_W  = 32;
   localparam int QUANT_W  = 16;
   localparam int INDEX_W  = 12;
   localparam int DIVD_W   = COORD_W + QUANT_W;   // dividend of one quantization
   localparam int BITCNT_W = $clog2(DIVD_W);

   // per-axis selection
   localparam logic [1:0] AXIS_FIRST = 2'd0;
   localparam logic [1:0] AXIS_LAST  = 2'd2;

   // corner reset values
   localparam logic [COORD_W-1:0] MOST_POS = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] MOST_NEG = 32'h8000_0000;

   // input kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // record types
   localparam logic REC_HEADER = 1'b0;
   localparam logic REC_ATOM   = 1'b1;

   // error codes
   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_ZERO_SPAN = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

   typedef enum logic [1:0] {
      PH_LOAD,
      PH_ATOMS,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_HDR,
      ST_READ,
      ST_MULT,
      ST_DIV,
      ST_ATOM
   } state_type;

endpackage

// ===== design/bounding_box_coordinate_quantizer.sv =====
// ----------------------------------------------------------------------------
// bounding_box_coordinate_quantizer - frame bounding box and 16-bit quantizer
// Loads atom positions, tracks the box corners, then drains a header and
// one quantized record per atom.
// ----------------------------------------------------------------------------
// Load commands (req_kind 0) leave the sequencer idle, so busy stays low. The
// first drain tick of a frame walks the three axes through one subtractor to
// find the largest span and gives the header (an empty frame skips the walk).
// Each further drain tick gives one atom record: a wait for the atom store
// read, then per axis one multiply step and a shared restoring divider over
// the 48-bit dividend at one quotient bit per cycle; with a zero span the
// divider is skipped and every quantized value is zero. Results appear for
// one cycle with rsp_valid and cannot be held off; busy is high while a drain
// is being worked on. A drain tick after the frame is fully sent gives no
// result.
module bounding_box_coordinate_quantizer #(
   parameter int MAX_ATOMS = 4096,
   parameter int QUANT_MAX = 65535
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_kind,
   input  logic signed [bbcq_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [bbcq_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [bbcq_pkg::COORD_W-1:0]   req_pos_z,
   output logic                                  rsp_valid,
   output logic                                  rsp_record_type,
   output logic        [bbcq_pkg::QUANT_W-1:0]   rsp_quant_x,
   output logic        [bbcq_pkg::QUANT_W-1:0]   rsp_quant_y,
   output logic        [bbcq_pkg::QUANT_W-1:0]   rsp_quant_z,
   output logic signed [bbcq_pkg::COORD_W-1:0]   rsp_origin_x,
   output logic signed [bbcq_pkg::COORD_W-1:0]   rsp_origin_y,
   output logic signed [bbcq_pkg::COORD_W-1:0]   rsp_origin_z,
   output logic        [bbcq_pkg::COORD_W-1:0]   rsp_max_span,
   output logic        [bbcq_pkg::INDEX_W-1:0]   rsp_atom_index,
   output logic                                  rsp_last,
   output logic        [1:0]                     rsp_error_code
);
   import bbcq_pkg::*;

   localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int CW = $clog2(MAX_ATOMS + 1);
   localparam logic [CW-1:0]     CAPACITY = CW'(MAX_ATOMS);
   localparam logic [DIVD_W-1:0] QSCALE   = DIVD_W'(QUANT_MAX);

   // sequencer and frame state
   state_type state_ff, state_in;
   phase_type phase_ff;
   logic [2:0][COORD_W-1:0] min_ff, max_ff;
   logic [CW-1:0]           count_ff, drain_ff;
   logic                    ovf_ff;
   logic [COORD_W-1:0]      span_ff;
   logic [1:0]              err_ff;
   logic [1:0]              axis_ff;

   // divider state
   logic [BITCNT_W-1:0]     bit_ff;
   logic [COORD_W-1:0]      rem_ff;
   logic [DIVD_W-1:0]       dvd_ff;
   logic [2:0][QUANT_W-1:0] quant_ff;

   // atom store
   logic [3*COORD_W-1:0]    mem [MAX_ATOMS];
   logic [2:0][COORD_W-1:0] rd_data_ff;

   // output registers
   logic                    rsp_valid_ff;
   logic                    rsp_type_ff;
   logic [2:0][QUANT_W-1:0] rsp_quant_ff;
   logic [2:0][COORD_W-1:0] rsp_origin_ff;
   logic [COORD_W-1:0]      rsp_span_ff;
   logic [INDEX_W-1:0]      rsp_index_ff;
   logic                    rsp_last_ff;
   logic [1:0]              rsp_err_ff;

   // ---------------------------------------------------------------------
   // accept decode and load path
   logic                    accept, do_load, do_drain, fresh, full, load_we;
   logic [CW-1:0]           count_eff;
   logic [2:0][COORD_W-1:0] min_eff, max_eff, pos, min_new, max_new;

   assign accept   = start && !busy;
   assign do_load  = accept && (req_kind == KIND_LOAD);
   assign do_drain = accept && (req_kind == KIND_DRAIN);
   assign fresh    = (phase_ff != PH_LOAD);
   assign count_eff = fresh ? '0 : count_ff;
   assign min_eff  = fresh ? {3{MOST_POS}} : min_ff;
   assign max_eff  = fresh ? {3{MOST_NEG}} : max_ff;
   assign full     = (count_eff == CAPACITY);
   assign load_we  = do_load && !full;
   assign pos      = {req_pos_z, req_pos_y, req_pos_x};

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         min_new[a] = ($signed(pos[a]) < $signed(min_eff[a])) ? pos[a] : min_eff[a];
         max_new[a] = ($signed(pos[a]) > $signed(max_eff[a])) ? pos[a] : max_eff[a];
      end
   end

   // ---------------------------------------------------------------------
   // shared arithmetic: axis span, offset product, divider step
   logic [COORD_W-1:0]  axis_span, diff;
   logic [COORD_W:0]    rem_sh;
   logic                rem_ge;
   logic [COORD_W-1:0]  rem_next;
   logic [DIVD_W-1:0]   dvd_next;
   logic                last_atom;
   logic [CW-1:0]       drain_inc;

   assign axis_span = max_ff[axis_ff] - min_ff[axis_ff];
   assign diff      = rd_data_ff[axis_ff] - min_ff[axis_ff];
   assign rem_sh    = {rem_ff, dvd_ff[DIVD_W-1]};
   assign rem_ge    = (rem_sh >= {1'b0, span_ff});
   assign rem_next  = rem_ge ? COORD_W'(rem_sh - {1'b0, span_ff}) : rem_sh[COORD_W-1:0];
   assign dvd_next  = {dvd_ff[DIVD_W-2:0], rem_ge};
   assign drain_inc = drain_ff + 1'b1;
   assign last_atom = (drain_inc == count_ff);

   // ---------------------------------------------------------------------
   // sequencer next state
   always_comb begin
      state_in = state_ff;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (do_drain) begin
               unique case (phase_ff)
                  PH_LOAD:  state_in = (count_ff != '0) ? ST_SPAN : ST_HDR;
                  PH_ATOMS: state_in = ST_READ;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_SPAN: begin
            if (axis_ff == AXIS_LAST) state_in = ST_HDR;
         end
         ST_HDR:  state_in = ST_IDLE;
         ST_READ: state_in = ST_MULT;
         ST_MULT: begin
            priority if (span_ff != '0) state_in = ST_DIV;
            else if (axis_ff == AXIS_LAST) state_in = ST_ATOM;
         end
         ST_DIV: begin
            if (bit_ff == '0) state_in = (axis_ff == AXIS_LAST) ? ST_ATOM : ST_MULT;
         end
         ST_ATOM: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------------------------------------------------------------
   // atom store: write on load, registered read at the drain index
   always_ff @(posedge clock) begin
      if (load_we) mem[count_eff[AW-1:0]] <= pos;
      rd_data_ff <= mem[drain_ff[AW-1:0]];
   end

   // ---------------------------------------------------------------------
   // frame control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LOAD;
         min_ff   <= {3{MOST_POS}};
         max_ff   <= {3{MOST_NEG}};
         count_ff <= '0;
         drain_ff <= '0;
         ovf_ff   <= 1'b0;
         err_ff   <= ERR_OK;
      end else begin
         if (do_load) begin
            phase_ff <= PH_LOAD;
            drain_ff <= fresh ? '0 : drain_ff;
            if (full) begin
               ovf_ff   <= 1'b1;
               min_ff   <= min_eff;
               max_ff   <= max_eff;
               count_ff <= count_eff;
            end else begin
               ovf_ff   <= fresh ? 1'b0 : ovf_ff;
               min_ff   <= min_new;
               max_ff   <= max_new;
               count_ff <= count_eff + 1'b1;
            end
         end
         if (state_ff == ST_HDR) begin
            drain_ff <= '0;
            phase_ff <= (count_ff != '0) ? PH_ATOMS : PH_DONE;
            err_ff   <= (span_ff == '0) ? ERR_ZERO_SPAN : (ovf_ff ? ERR_OVERFLOW : ERR_OK);
         end
         if (state_ff == ST_ATOM) begin
            drain_ff <= drain_inc;
            if (last_atom) phase_ff <= PH_DONE;
         end
      end
   end

   // ---------------------------------------------------------------------
   // span search and quantization datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            axis_ff <= AXIS_FIRST;
            if (do_drain && phase_ff == PH_LOAD) span_ff <= '0;
         end
         ST_SPAN: begin
            if (axis_span > span_ff) span_ff <= axis_span;
            axis_ff <= axis_ff + 1'b1;
         end
         ST_MULT: begin
            dvd_ff <= {{QUANT_W{1'b0}}, diff} * QSCALE;
            rem_ff <= '0;
            bit_ff <= BITCNT_W'(DIVD_W - 1);
            if (span_ff == '0) begin
               quant_ff[axis_ff] <= '0;
               axis_ff <= axis_ff + 1'b1;
            end
         end
         ST_DIV: begin
            rem_ff <= rem_next;
            dvd_ff <= dvd_next;
            bit_ff <= bit_ff - 1'b1;
            if (bit_ff == '0) begin
               quant_ff[axis_ff] <= dvd_next[QUANT_W-1:0];
               axis_ff <= axis_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // result registers, one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= (state_ff == ST_HDR) || (state_ff == ST_ATOM);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_HDR) begin
         rsp_type_ff   <= REC_HEADER;
         rsp_quant_ff  <= '0;
         rsp_origin_ff <= (count_ff != '0) ? min_ff : '0;
         rsp_span_ff   <= span_ff;
         rsp_index_ff  <= '0;
         rsp_last_ff   <= 1'b0;
         rsp_err_ff    <= (span_ff == '0) ? ERR_ZERO_SPAN : (ovf_ff ? ERR_OVERFLOW : ERR_OK);
      end else if (state_ff == ST_ATOM) begin
         rsp_type_ff   <= REC_ATOM;
         rsp_quant_ff  <= quant_ff;
         rsp_origin_ff <= '0;
         rsp_span_ff   <= '0;
         rsp_index_ff  <= INDEX_W'(drain_ff);
         rsp_last_ff   <= last_atom;
         rsp_err_ff    <= err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_record_type = rsp_type_ff;
   assign rsp_quant_x     = rsp_quant_ff[0];
   assign rsp_quant_y     = rsp_quant_ff[1];
   assign rsp_quant_z     = rsp_quant_ff[2];
   assign rsp_origin_x    = rsp_origin_ff[0];
   assign rsp_origin_y    = rsp_origin_ff[1];
   assign rsp_origin_z    = rsp_origin_ff[2];
   assign rsp_max_span    = rsp_span_ff;
   assign rsp_atom_index  = rsp_index_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_error_code  = rsp_err_ff;

`ifndef SYNTHESIS
   // a result only leaves once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");

   // header flags zero span exactly when the span is zero
   a_hdr_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_type == REC_HEADER) |->
         ((rsp_max_span == '0) == (rsp_error_code == ERR_ZERO_SPAN)))
      else $error("header error code does not match span");

   // quantized offsets stay within the scale
   a_quant_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_type == REC_ATOM) |->
         (32'(rsp_quant_x) <= QUANT_MAX && 32'(rsp_quant_y) <= QUANT_MAX &&
          32'(rsp_quant_z) <= QUANT_MAX))
      else $error("quantized value above scale");

   // atom count never passes capacity, drain index never passes count
   a_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CAPACITY) && (phase_ff != PH_ATOMS || drain_ff < count_ff))
      else $error("atom count or drain index out of range");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the bounding box coordinate quantizer
// Loads frames of atom positions and drains them, with a local predictor
// of the box corners, the header and the quantized records. Every record
// that leaves the block is compared field by field with the prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import bbcq_pkg::*;

   localparam int ATOM_CAP  = 4096;
   localparam int ATOM_AW   = $clog2(ATOM_CAP);
   localparam int QUANT_TOP = 65535;
   localparam int RANDOM_CMDS = 1000;

   typedef logic [2:0][COORD_W-1:0] xyz_type;   // [0] = x, [1] = y, [2] = z

   typedef struct {
      logic    kind;
      xyz_type pos;
      int      gap;    // idle cycles before the command is offered
      bit      hold;   // wait until all records are back before offering it
   } quant_cmd_type;

   typedef struct packed {
      logic                          record_type;
      logic [2:0][QUANT_W-1:0]       quant;
      logic [2:0][COORD_W-1:0]       origin;
      logic [COORD_W-1:0]            max_span;
      logic [INDEX_W-1:0]            atom_index;
      logic                          last;
      logic [1:0]                    error_code;
   } box_record_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = KIND_LOAD;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic signed [COORD_W-1:0] req_pos_z = '0;
   logic rsp_valid;
   logic rsp_record_type;
   logic [QUANT_W-1:0] rsp_quant_x, rsp_quant_y, rsp_quant_z;
   logic signed [COORD_W-1:0] rsp_origin_x, rsp_origin_y, rsp_origin_z;
   logic [COORD_W-1:0] rsp_max_span;
   logic [INDEX_W-1:0] rsp_atom_index;
   logic rsp_last;
   logic [1:0] rsp_error_code;

   bounding_box_coordinate_quantizer #(
      .MAX_ATOMS(ATOM_CAP),
      .QUANT_MAX(QUANT_TOP)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .rsp_valid      (rsp_valid),
      .rsp_record_type(rsp_record_type),
      .rsp_quant_x    (rsp_quant_x),
      .rsp_quant_y    (rsp_quant_y),
      .rsp_quant_z    (rsp_quant_z),
      .rsp_origin_x   (rsp_origin_x),
      .rsp_origin_y   (rsp_origin_y),
      .rsp_origin_z   (rsp_origin_z),
      .rsp_max_span   (rsp_max_span),
      .rsp_atom_index (rsp_atom_index),
      .rsp_last       (rsp_last),
      .rsp_error_code (rsp_error_code)
   );

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   quant_cmd_type  pending_cmds[$];
   box_record_type expected_records[$];
   quant_cmd_type  next_cmd;
   bit             have_next = 1'b0;
   int             n_issued = 0;
   int             n_taken = 0;
   int             n_total = 0;
   int             n_fail = 0;
   bit             quiet_run = 1'b0;
   bit             hold_next = 1'b0;
   box_record_type want_rec;

   // frame predictor state
   xyz_type          atom_pos [ATOM_CAP];
   xyz_type          box_lo, box_hi;
   int               n_atoms, drain_ptr;
   phase_type        frame_phase;
   bit               loads_dropped;
   logic [COORD_W-1:0] frame_span;
   logic [1:0]       frame_err;

   task automatic clear_frame();
      for (int a = 0; a < 3; a++) begin
         box_lo[a] = MOST_POS;
         box_hi[a] = MOST_NEG;
      end
      n_atoms       = 0;
      drain_ptr     = 0;
      frame_phase   = PH_LOAD;
      loads_dropped = 1'b0;
      frame_span    = '0;
      frame_err     = ERR_OK;
   endtask

   // advance the frame by one accepted command, queue the record it gives
   task automatic predict_command(input logic kind, input xyz_type pos);
      box_record_type     rec;
      logic [COORD_W-1:0] extent;
      logic [COORD_W-1:0] offset;
      logic [63:0]        scaled;
      rec = '0;
      if (kind == KIND_LOAD) begin
         if (frame_phase != PH_LOAD) clear_frame();
         if (n_atoms >= ATOM_CAP) begin
            loads_dropped = 1'b1;
         end else begin
            atom_pos[ATOM_AW'(n_atoms)] = pos;
            for (int a = 0; a < 3; a++) begin
               if ($signed(pos[a]) < $signed(box_lo[a])) box_lo[a] = pos[a];
               if ($signed(pos[a]) > $signed(box_hi[a])) box_hi[a] = pos[a];
            end
            n_atoms++;
         end
      end else if (frame_phase == PH_LOAD) begin
         // header: origin and largest extent
         frame_span = '0;
         if (n_atoms != 0) begin
            for (int a = 0; a < 3; a++) begin
               extent = box_hi[a] - box_lo[a];
               if (extent > frame_span) frame_span = extent;
               rec.origin[a] = box_lo[a];
            end
         end
         if (frame_span == 0) frame_err = ERR_ZERO_SPAN;
         else if (loads_dropped) frame_err = ERR_OVERFLOW;
         else frame_err = ERR_OK;
         rec.record_type = REC_HEADER;
         rec.max_span    = frame_span;
         rec.error_code  = frame_err;
         drain_ptr       = 0;
         frame_phase     = (n_atoms != 0) ? PH_ATOMS : PH_DONE;
         expected_records.push_back(rec);
      end else if (frame_phase == PH_ATOMS) begin
         // atom record: floor(offset * QUANT_TOP / span) per axis
         rec.record_type = REC_ATOM;
         for (int a = 0; a < 3; a++) begin
            if (frame_span != 0) begin
               offset = atom_pos[ATOM_AW'(drain_ptr)][a] - box_lo[a];
               scaled = {32'b0, offset} * 64'(QUANT_TOP);
               scaled = scaled / {32'b0, frame_span};
               rec.quant[a] = scaled[QUANT_W-1:0];
            end
         end
         rec.atom_index = INDEX_W'(drain_ptr);
         rec.error_code = frame_err;
         drain_ptr++;
         if (drain_ptr >= n_atoms) begin
            rec.last    = 1'b1;
            frame_phase = PH_DONE;
         end
         expected_records.push_back(rec);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         n_fail++;
      end
   endtask

   // monitor: check records, then predict the accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
      end else begin
         if (rsp_valid) begin
            if (expected_records.size() == 0) begin
               $error("record arrived with none expected");
               n_fail++;
            end else begin
               want_rec = expected_records.pop_front();
               check_field("record_type", 32'(want_rec.record_type),
                           32'(rsp_record_type));
               check_field("quant_x", 32'(want_rec.quant[0]), 32'(rsp_quant_x));
               check_field("quant_y", 32'(want_rec.quant[1]), 32'(rsp_quant_y));
               check_field("quant_z", 32'(want_rec.quant[2]), 32'(rsp_quant_z));
               check_field("origin_x", want_rec.origin[0], rsp_origin_x);
               check_field("origin_y", want_rec.origin[1], rsp_origin_y);
               check_field("origin_z", want_rec.origin[2], rsp_origin_z);
               check_field("max_span", want_rec.max_span, rsp_max_span);
               check_field("atom_index", 32'(want_rec.atom_index),
                           32'(rsp_atom_index));
               check_field("last", 32'(want_rec.last), 32'(rsp_last));
               check_field("error_code", 32'(want_rec.error_code),
                           32'(rsp_error_code));
            end
         end
         if (start && !busy) begin
            predict_command(req_kind, {req_pos_z, req_pos_y, req_pos_x});
            n_taken++;
         end
      end
   end

   // driver: offer queued commands at the falling edge
   always @(negedge clock) begin
      if (!have_next && pending_cmds.size() != 0) begin
         next_cmd  = pending_cmds.pop_front();
         have_next = 1'b1;
      end
      if (reset) begin
         start <= 1'b0;
      end else if (start && n_taken != n_issued) begin
         // transfer still pending, hold everything
      end else if (!have_next) begin
         start <= 1'b0;
      end else if (next_cmd.gap > 0) begin
         next_cmd.gap--;
         start <= 1'b0;
      end else if (next_cmd.hold && expected_records.size() != 0) begin
         start <= 1'b0;
      end else begin
         req_kind  <= next_cmd.kind;
         req_pos_x <= next_cmd.pos[0];
         req_pos_y <= next_cmd.pos[1];
         req_pos_z <= next_cmd.pos[2];
         start     <= 1'b1;
         have_next = 1'b0;
         n_issued++;
      end
   end

   function automatic xyz_type xyz(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z);
      return {z, y, x};
   endfunction

   task automatic queue_cmd(input logic kind, input xyz_type pos);
      quant_cmd_type c;
      c.kind = kind;
      c.pos  = pos;
      c.gap  = quiet_run ? 0 : $urandom_range(0, 4);
      c.hold = hold_next;
      hold_next = 1'b0;
      pending_cmds.push_back(c);
   endtask

   // one random frame: loads of some shape, then a full or cut-short drain
   task automatic add_random_frame();
      int      n, style, spread, drains;
      xyz_type base, p;
      n      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                           : $urandom_range(1, 12);
      style  = $urandom_range(0, 4);
      spread = $urandom_range(0, 24);
      base   = xyz($urandom, $urandom, $urandom);
      quiet_run = ($urandom_range(0, 5) == 0);
      // occasional noise ahead of the frame
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3))
            queue_cmd(($urandom_range(0, 1) == 0) ? KIND_LOAD : KIND_DRAIN,
                      xyz($urandom, $urandom, $urandom));
      end
      for (int i = 0; i < n; i++) begin
         for (int a = 0; a < 3; a++) begin
            case (style)
               0: p[a] = $urandom;
               1: p[a] = base[a] + ($urandom & ((32'd1 << spread) - 1));
               2: p[a] = base[a];
               3: begin
                  case ($urandom_range(0, 3))
                     0: p[a] = MOST_POS;
                     1: p[a] = MOST_NEG;
                     2: p[a] = '0;
                     default: p[a] = $urandom;
                  endcase
               end
               default: p[a] = (a == 0) ? base[a] : $urandom;
            endcase
         end
         hold_next = ($urandom_range(0, 49) == 0);
         queue_cmd(KIND_LOAD, p);
      end
      // mostly header, every atom and up to two ticks past the end
      drains = ($urandom_range(0, 6) == 0) ? $urandom_range(1, n)
                                           : n + 1 + $urandom_range(0, 2);
      repeat (drains) queue_cmd(KIND_DRAIN, xyz($urandom, $urandom, $urandom));
   endtask

   // stimulus and end of test
   initial begin
      int random_base;

      // empty frame right after reset, then a tick past its end
      queue_cmd(KIND_DRAIN, xyz(32'h1234_5678, MOST_NEG, MOST_POS));
      queue_cmd(KIND_DRAIN, '0);
      // full-range extremes, span of all ones
      queue_cmd(KIND_LOAD, xyz(MOST_NEG, MOST_NEG, MOST_NEG));
      queue_cmd(KIND_LOAD, xyz(MOST_POS, MOST_POS, MOST_POS));
      queue_cmd(KIND_LOAD, xyz(32'h0, 32'h0001_0000, 32'hFFFF_FFFF));
      repeat (5) queue_cmd(KIND_DRAIN, '0);
      // zero span, sender waits for the bench to go quiet first
      hold_next = 1'b1;
      queue_cmd(KIND_LOAD, xyz(32'd5, 32'd5, 32'd5));
      queue_cmd(KIND_LOAD, xyz(32'd5, 32'd5, 32'd5));
      repeat (3) queue_cmd(KIND_DRAIN, '0);
      // load in the middle of a drain opens a new single-atom frame
      queue_cmd(KIND_LOAD, xyz(32'd1, 32'd2, 32'd3));
      queue_cmd(KIND_LOAD, xyz(32'd100, -32'sd50, 32'd7));
      repeat (2) queue_cmd(KIND_DRAIN, '0);
      queue_cmd(KIND_LOAD, xyz(32'd9, 32'd9, 32'd9));
      repeat (3) queue_cmd(KIND_DRAIN, '0);

      hold_next = 1'b1;
      random_base = pending_cmds.size();
      while (pending_cmds.size() - random_base < RANDOM_CMDS) add_random_frame();
      n_total = pending_cmds.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (n_taken != n_total || expected_records.size() != 0) @(negedge clock);
      repeat (400) @(posedge clock);
      if (n_fail == 0) begin
         $display("bounding_box_coordinate_quantizer: match");
      end else begin
         $display("bounding_box_coordinate_quantizer: mismatch");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #120_000_000;
      $display("bounding_box_coordinate_quantizer: mismatch");
      $finish;
   end

endmodule
